FILE: sv/radix_string_converter_unit_assert.svh
// assertion helpers shared by the converter modules
// each use expects clk and arst_n in scope
`ifndef RADIX_STRING_CONVERTER_UNIT_ASSERT_SVH
`define RADIX_STRING_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication
`define RSC_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/rsc_pkg.sv
package rsc_pkg;

	localparam int MAX_DIGITS_DEF = 64;

	localparam int BASE_W    = 5;
	localparam int SYM_W     = 64;
	localparam int CHAR_W    = 8;
	localparam int ST_W      = 2;
	localparam int VAL_W     = 63;
	localparam int DIG_W     = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
	localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;
	localparam logic [CHAR_W-1:0] NULL_CHAR  = 8'h00;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_UNKNOWN  = 2'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TGT_BASE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_LO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HI   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TGT_LO   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TGT_HI   = 3'd5;

	localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

	typedef struct packed {
		logic [CHAR_W-1:0] in_char;
		logic              in_last;
	} in_word_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              out_last;
		logic [ST_W-1:0]   status;
	} out_word_t;

	// one alphabet: size and sixteen symbol bytes
	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic [SYM_W-1:0]  sym_lo;
		logic [SYM_W-1:0]  sym_hi;
	} alpha_cfg_t;

	// finished number handed from front to back
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             negative;
		logic [ST_W-1:0]  status;
	} job_t;

	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		r = b;
		if (b < BASE_MIN) r = BASE_MIN;
		else if (b > BASE_MAX) r = BASE_MAX;
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] symbol_at(input logic [SYM_W-1:0] lo,
		input logic [SYM_W-1:0] hi, input logic [DIG_W-1:0] k);
		logic [SYM_W-1:0] w;
		w = k[DIG_W-1] ? hi : lo;
		return w[{k[DIG_W-2:0], 3'b000} +: CHAR_W];
	endfunction

endpackage

FILE: sv/rsc_ram.sv
module rsc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: sv/rsc_front.sv
module rsc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  rsc_pkg::in_word_t   in_word,
	input  rsc_pkg::alpha_cfg_t src_cfg,
	input  logic                job_full,
	output logic                job_push,
	output rsc_pkg::job_t       job
);
	import rsc_pkg::*;

	logic                          valid_s1;
	in_word_t                      word_s1;
	logic [VAL_W-1:0]              acc_q;
	logic                          neg_q;
	logic                          first_q;
	logic [ST_W-1:0]               err_q;

	logic                          stall;
	logic                          accept;
	logic                          advance;
	logic [BASE_W-1:0]             base;
	logic                          found;
	logic [DIG_W-1:0]              digit;
	logic [VAL_W+BASE_W-1:0]       prod;
	logic [VAL_W+BASE_W-1:0]       sum;
	logic                          ovf;
	logic [VAL_W-1:0]              acc_n;
	logic                          neg_n;
	logic [ST_W-1:0]               err_n;

	// a last character waits here until the job queue has room
	assign stall   = valid_s1 && word_s1.in_last && job_full;
	assign full    = stall;
	assign accept  = push && !full;
	assign advance = valid_s1 && !stall;

	assign base = clamp_base(src_cfg.base);

	// lowest matching symbol within the base wins
	always_comb begin
		found = 1'b0;
		digit = '0;
		for (int k = 15; k >= 0; k--) begin
			if (BASE_W'(k) < base &&
				symbol_at(src_cfg.sym_lo, src_cfg.sym_hi, DIG_W'(k)) == word_s1.in_char) begin
				found = 1'b1;
				digit = DIG_W'(k);
			end
		end
	end

	assign prod = (VAL_W+BASE_W)'(acc_q) * (VAL_W+BASE_W)'(base);
	assign sum  = prod + (VAL_W+BASE_W)'(digit);
	assign ovf  = |sum[VAL_W+BASE_W-1:VAL_W];

	always_comb begin
		acc_n = acc_q;
		neg_n = neg_q;
		err_n = err_q;
		if (first_q && word_s1.in_char == MINUS_CHAR) begin
			neg_n = 1'b1;
		end else if (err_q == ST_OK) begin
			if (!found) err_n = ST_UNKNOWN;
			else if (ovf) err_n = ST_OVERFLOW;
			else acc_n = sum[VAL_W-1:0];
		end
	end

	assign job_push = advance && word_s1.in_last;
	assign job      = '{value: acc_n, negative: neg_n, status: err_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			neg_q   <= 1'b0;
			first_q <= 1'b1;
			err_q   <= ST_OK;
		end else if (advance) begin
			if (word_s1.in_last) begin
				acc_q   <= '0;
				neg_q   <= 1'b0;
				first_q <= 1'b1;
				err_q   <= ST_OK;
			end else begin
				acc_q   <= acc_n;
				neg_q   <= neg_n;
				first_q <= 1'b0;
				err_q   <= err_n;
			end
		end
	end
endmodule

FILE: sv/rsc_job_fifo.sv
`include "radix_string_converter_unit_assert.svh"

module rsc_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rsc_pkg::job_t wr_job,
	output logic          full,
	input  logic          pop,
	output rsc_pkg::job_t rd_job,
	output logic          empty
);
	import rsc_pkg::*;

	job_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full   = cnt_q == 2'd2;
	assign empty  = cnt_q == 2'd0;
	assign rd_job = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	`RSC_ASSERT_IMPLY(a_push_room, push, !full, "job queue written while full")
	`RSC_ASSERT_IMPLY(a_pop_data, pop, !empty, "job queue read while empty")
endmodule

FILE: sv/rsc_back.sv
`include "radix_string_converter_unit_assert.svh"

module rsc_back #(
	parameter int MAX_DIGITS = rsc_pkg::MAX_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rsc_pkg::alpha_cfg_t tgt_cfg,
	input  logic                job_empty,
	input  rsc_pkg::job_t       head_job,
	output logic                job_pop,
	input  logic                pop,
	output logic                empty,
	output rsc_pkg::out_word_t  out_word
);
	import rsc_pkg::*;

	localparam int CW        = $clog2(MAX_DIGITS + 1);
	localparam int AW        = $clog2(MAX_DIGITS);
	localparam int DIV_W     = 64;
	localparam int DIV_BITS  = 8;
	localparam int STEP_W    = $clog2(DIV_W / DIV_BITS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W / DIV_BITS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_RD,
		S_DATA
	} state_t;

	state_t            state_q;
	logic [DIV_W-1:0]  v_q;
	logic              neg_q;
	logic [CW-1:0]     cnt_q;
	logic [STEP_W-1:0] step_q;
	logic [DIG_W-1:0]  rem_q;
	logic              out_valid_q;
	out_word_t         out_q;

	logic [BASE_W-1:0] tbase;
	logic              out_free;
	logic              out_load;
	logic [DIV_W-1:0]  v_div;
	logic [DIG_W-1:0]  r_div;
	logic [BASE_W-1:0] t_div;
	logic [CW:0]       cnt_sign;
	logic              at_limit;
	logic [CW-1:0]     cnt_dec;
	logic              ram_we;
	logic [DIG_W-1:0]  ram_rdata;
	logic [CHAR_W-1:0] digit_sym;

	assign tbase    = clamp_base(tgt_cfg.base);
	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign out_word = out_q;
	assign job_pop  = state_q == S_IDLE && !job_empty && out_free;

	// restoring division by the target base, a byte of dividend per cycle
	always_comb begin
		v_div = v_q;
		r_div = rem_q;
		t_div = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			t_div = {r_div, v_div[DIV_W-1]};
			v_div = {v_div[DIV_W-2:0], 1'b0};
			if (t_div >= tbase) begin
				t_div    = t_div - tbase;
				v_div[0] = 1'b1;
			end
			r_div = t_div[DIG_W-1:0];
		end
	end

	assign cnt_sign = (CW+1)'(cnt_q) + (CW+1)'(neg_q);
	assign at_limit = cnt_sign >= (CW+1)'(MAX_DIGITS);
	assign cnt_dec  = cnt_q - CW'(1);
	assign ram_we   = state_q == S_DIV && step_q == STEP_LAST;

	// a word is loaded into the output register this cycle
	assign out_load = (job_pop && (head_job.status != ST_OK || head_job.value == '0))
		|| (state_q == S_CHECK && out_free && ((v_q == '0) ? neg_q : at_limit))
		|| (state_q == S_DATA && out_free);

	// least significant digit sits at address zero
	rsc_ram #(
		.WIDTH (DIG_W),
		.DEPTH (MAX_DIGITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (r_div),
		.raddr (cnt_dec[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign digit_sym = symbol_at(tgt_cfg.sym_lo, tgt_cfg.sym_hi, ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			v_q         <= '0;
			neg_q       <= 1'b0;
			cnt_q       <= '0;
			step_q      <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_pop) begin
						if (head_job.status != ST_OK) begin
							out_q       <= '{out_char: NULL_CHAR, out_last: 1'b1,
								status: head_job.status};
						end else if (head_job.value == '0) begin
							out_q       <= '{out_char: ZERO_CHAR, out_last: 1'b1,
								status: ST_OK};
						end else begin
							v_q     <= DIV_W'(head_job.value);
							neg_q   <= head_job.negative;
							cnt_q   <= '0;
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (v_q == '0) begin
						if (neg_q) begin
							if (out_free) begin
								out_q       <= '{out_char: MINUS_CHAR, out_last: 1'b0,
									status: ST_OK};
								state_q     <= S_RD;
							end
						end else begin
							state_q <= S_RD;
						end
					end else if (at_limit) begin
						if (out_free) begin
							out_q       <= '{out_char: NULL_CHAR, out_last: 1'b1,
								status: ST_OVERFLOW};
							state_q     <= S_IDLE;
						end
					end else begin
						step_q  <= '0;
						rem_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					v_q    <= v_div;
					rem_q  <= r_div;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_CHECK;
					end
				end
				S_RD: begin
					state_q <= S_DATA;
				end
				S_DATA: begin
					if (out_free) begin
						out_q       <= '{out_char: digit_sym, out_last: cnt_q == CW'(1),
							status: ST_OK};
						cnt_q       <= cnt_dec;
						state_q     <= (cnt_q == CW'(1)) ? S_IDLE : S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`RSC_ASSERT_IMPLY(a_rem_below_base, state_q == S_DIV, BASE_W'(rem_q) < tbase, "bad remainder")
	`RSC_ASSERT_IMPLY(a_read_has_digit, state_q == S_RD || state_q == S_DATA, |cnt_q, "no digit")
	`RSC_ASSERT_IMPLY(a_cnt_bound, state_q == S_DIV, cnt_q < CW'(MAX_DIGITS), "digit past buffer")
	`RSC_ASSERT_NEXT(a_div_returns, ram_we, state_q == S_CHECK, "division did not end in check")
endmodule

FILE: sv/radix_string_converter_unit.sv
// flow: each character is folded in by the front; an error or zero word is loaded
//   straight from the job queue, else each target digit takes one division step per
//   dividend byte plus one check, then the sign and the digits leave msd first
// throughput: one character per cycle in while full is low; each digit word waits on
//   a read state for the registered digit buffer read; new jobs start only from idle
// reset: arst_n clears all control state at once, sizes go to 2, alphabets to zero
module radix_string_converter_unit #(
	parameter int MAX_DIGITS = rsc_pkg::MAX_DIGITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  rsc_pkg::in_word_t               in_word,
	output logic                            empty,
	input  logic                            pop,
	output rsc_pkg::out_word_t              out_word,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsc_pkg::SYM_W-1:0]       cfg_data
);
	import rsc_pkg::*;

	// configuration registers, to be written only while idle; the block does not enforce this
	alpha_cfg_t src_cfg_q;
	alpha_cfg_t tgt_cfg_q;

	// front to queue
	logic job_push;
	job_t job_in;
	logic job_full;

	// queue to back
	logic job_pop;
	job_t job_head;
	logic job_empty;

	// registers never stall a write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cfg_q <= '{base: BASE_MIN, sym_lo: '0, sym_hi: '0};
			tgt_cfg_q <= '{base: BASE_MIN, sym_lo: '0, sym_hi: '0};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SRC_BASE: src_cfg_q.base   <= cfg_data[BASE_W-1:0];
				REG_TGT_BASE: tgt_cfg_q.base   <= cfg_data[BASE_W-1:0];
				REG_SRC_LO:   src_cfg_q.sym_lo <= cfg_data;
				REG_SRC_HI:   src_cfg_q.sym_hi <= cfg_data;
				REG_TGT_LO:   tgt_cfg_q.sym_lo <= cfg_data;
				REG_TGT_HI:   tgt_cfg_q.sym_hi <= cfg_data;
				// unused indexes are dropped
				default: begin
				end
			endcase
		end
	end

	// front: sign detection, symbol lookup, accumulate with overflow check
	rsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_word  (in_word),
		.src_cfg  (src_cfg_q),
		.job_full (job_full),
		.job_push (job_push),
		.job      (job_in)
	);

	// two-entry queue so the front keeps taking characters during a conversion
	rsc_job_fifo u_jobs (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wr_job (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.rd_job (job_head),
		.empty  (job_empty)
	);

	// back: repeated division into the digit buffer, then emit msd first
	rsc_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tgt_cfg   (tgt_cfg_q),
		.job_empty (job_empty),
		.head_job  (job_head),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.out_word  (out_word)
	);
endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

// radix string converter check: digit characters stream in one word at a time,
// converted characters stream out, and every output word is compared against a
// local conversion model or a hand-written expectation in arrival order
module testbench;
	import rsc_pkg::*;

	localparam int DIGIT_CAP = MAX_DIGITS_DEF;
	localparam int CYCLE_LIMIT = 2000000;
	// cycles left for the front end to settle once all results are out
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES = 100;
	localparam int PHASE_ITEMS = 42;
	localparam int PRINT_CAP = 40;
	localparam logic [63:0] VALUE_CAP = 64'h7FFF_FFFF_FFFF_FFFF;

	// register slots the block does not use, written once to see them ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	// plain decimal/hex alphabet, symbol k in byte k
	localparam logic [63:0] HEX_SYMS_LO = 64'h3736_3534_3332_3130;
	localparam logic [63:0] HEX_SYMS_HI = 64'h4645_4443_4241_3938;

	typedef enum logic {ROW_CFG, ROW_CHAR} row_kind_t;

	// one line of the directed table: a register write or a character word
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [SYM_W-1:0]      reg_data;
		in_word_t              word;
		logic                  typed;
		out_word_t             want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	in_word_t              in_word = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	out_word_t             out_word;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [SYM_W-1:0]      cfg_data = '0;

	radix_string_converter_unit #(
		.MAX_DIGITS(DIGIT_CAP)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_word(in_word),
		.empty(empty),
		.pop(pop),
		.out_word(out_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// local copy of the register file
	logic [BASE_W-1:0] src_size_q = 5'd2;
	logic [BASE_W-1:0] tgt_size_q = 5'd2;
	logic [SYM_W-1:0]  src_lo_q = '0;
	logic [SYM_W-1:0]  src_hi_q = '0;
	logic [SYM_W-1:0]  tgt_lo_q = '0;
	logic [SYM_W-1:0]  tgt_hi_q = '0;

	// per-number accumulation state
	logic [VAL_W-1:0]  acc_q = '0;
	bit                neg_q = 1'b0;
	bit                first_q = 1'b1;
	logic [ST_W-1:0]   err_q = ST_OK;

	out_word_t   awaited_words[$];
	stim_row_t   stim_table[$];
	int          mismatch_count = 0;
	int          result_index = 0;
	int          items_sent = 0;
	bit          number_open = 1'b0;
	int          cycle_count = 0;

	// receiver stall bookkeeping
	int          stall_left = 0;
	int          calm_left = 0;
	int          pop_roll;

	// sizes outside 2..16 behave as the nearest bound
	function automatic int eff_base(logic [BASE_W-1:0] size);
		if (size < 5'd2)
			return 2;
		if (size > 5'd16)
			return 16;
		return int'(size);
	endfunction

	function automatic logic [7:0] alpha_byte(logic [63:0] lo, logic [63:0] hi, int k);
		logic [127:0] both;
		both = {hi, lo};
		return both[k*8 +: 8];
	endfunction

	function automatic out_word_t result_word(logic [7:0] c, logic last, logic [ST_W-1:0] st);
		out_word_t r;
		r.out_char = c;
		r.out_last = last;
		r.status = st;
		return r;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [SYM_W-1:0] data);
		case (idx)
			REG_SRC_BASE: src_size_q = data[BASE_W-1:0];
			REG_TGT_BASE: tgt_size_q = data[BASE_W-1:0];
			REG_SRC_LO:   src_lo_q = data;
			REG_SRC_HI:   src_hi_q = data;
			REG_TGT_LO:   tgt_lo_q = data;
			REG_TGT_HI:   tgt_hi_q = data;
			default: ;
		endcase
	endfunction

	// look a character up in the source alphabet and fold it into the value
	function automatic void fold_digit(logic [7:0] ch);
		int base;
		int d;
		bit hit;
		base = eff_base(src_size_q);
		d = 0;
		hit = 1'b0;
		// lowest matching slot wins when symbols repeat
		for (int k = 0; k < base; k++) begin
			if (!hit && alpha_byte(src_lo_q, src_hi_q, k) == ch) begin
				d = k;
				hit = 1'b1;
			end
		end
		// first error of a number sticks
		if (err_q != ST_OK)
			return;
		if (!hit) begin
			err_q = ST_UNKNOWN;
			return;
		end
		if ({1'b0, acc_q} > (VALUE_CAP - 64'(d)) / 64'(base)) begin
			err_q = ST_OVERFLOW;
			return;
		end
		acc_q = acc_q * 63'(base) + 63'(d);
	endfunction

	// advance the number state by one character word, queue any output words
	function automatic void absorb_char(in_word_t w);
		logic [3:0]  digit_stack[0:127];
		logic [63:0] v;
		int          base;
		int          count;
		int          sign;
		// a minus only counts as a sign in the first position
		if (first_q && w.in_char == MINUS_CHAR)
			neg_q = 1'b1;
		else
			fold_digit(w.in_char);
		first_q = 1'b0;
		if (!w.in_last)
			return;
		if (err_q != ST_OK) begin
			awaited_words.push_back(result_word(NULL_CHAR, 1'b1, err_q));
		end else if (acc_q == '0) begin
			// zero is printed bare, never signed
			awaited_words.push_back(result_word(ZERO_CHAR, 1'b1, ST_OK));
		end else begin
			base = eff_base(tgt_size_q);
			sign = neg_q ? 1 : 0;
			v = {1'b0, acc_q};
			count = 0;
			while (v != 0 && count + sign < DIGIT_CAP) begin
				digit_stack[count] = 4'(v % 64'(base));
				v = v / 64'(base);
				count++;
			end
			if (v != 0) begin
				// sign plus digits do not fit the digit buffer
				awaited_words.push_back(result_word(NULL_CHAR, 1'b1, ST_OVERFLOW));
			end else begin
				if (sign != 0)
					awaited_words.push_back(result_word(MINUS_CHAR, 1'b0, ST_OK));
				for (int k = count - 1; k >= 0; k--) begin
					awaited_words.push_back(result_word(
						alpha_byte(tgt_lo_q, tgt_hi_q, int'(digit_stack[k])),
						k == 0, ST_OK));
				end
			end
		end
		// number done, back to a clean start
		acc_q = '0;
		neg_q = 1'b0;
		first_q = 1'b1;
		err_q = ST_OK;
	endfunction

	// directed table builders
	function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [SYM_W-1:0] data);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.reg_index = idx;
		r.reg_data = data;
		stim_table.push_back(r);
	endfunction

	function automatic void row_char(logic [7:0] c, logic last);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CHAR;
		r.word.in_char = c;
		r.word.in_last = last;
		stim_table.push_back(r);
	endfunction

	function automatic void row_typed(logic [7:0] c, logic last, out_word_t want);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CHAR;
		r.word.in_char = c;
		r.word.in_last = last;
		r.typed = 1'b1;
		r.want = want;
		stim_table.push_back(r);
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch on %s at result %0d: got %0h, wanted %0h", what,
				result_index, got, want);
	endtask

	// offer one character word and wait for the block to take it
	task automatic send_char(in_word_t w, bit typed, out_word_t want);
		int queued_count;
		push <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
		number_open = !w.in_last;
		queued_count = awaited_words.size();
		absorb_char(w);
		// hand-written expectation replaces the model's for this row
		if (typed) begin
			while (awaited_words.size() > queued_count)
				void'(awaited_words.pop_back());
			awaited_words.push_back(want);
		end
	endtask

	// gap after a word: mostly none or short, now and then long
	task automatic sender_idle(bit burst);
		int roll;
		roll = $urandom_range(0, 99);
		if (burst || roll < 55)
			return;
		push <= 1'b0;
		if (roll < 90)
			repeat ($urandom_range(1, 3)) @(posedge clk);
		else
			repeat ($urandom_range(8, 40)) @(posedge clk);
	endtask

	// hold the sender until every queued result is out, then let the block settle
	task automatic drain_results();
		push <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// valid stays up across back to back writes; caller drops it after the batch
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SYM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
	endtask

	// per-phase register setup: fixed extremes first, random settings later
	task automatic configure(int phase);
		logic [127:0] src_syms;
		logic [127:0] tgt_syms;
		logic [63:0]  src_word;
		logic [63:0]  tgt_word;
		bit           taken[256];
		logic [7:0]   b;
		int           a_pos;
		int           b_pos;
		int           src_b;
		drain_results();
		src_word = {$urandom(), $urandom()};
		tgt_word = {$urandom(), $urandom()};
		case (phase)
			0: begin
				src_word[4:0] = 5'd2;
				tgt_word[4:0] = 5'd16;
			end
			1: begin
				src_word[4:0] = 5'd16;
				tgt_word[4:0] = 5'd2;
			end
			2: begin
				src_word[4:0] = 5'd16;
				tgt_word[4:0] = 5'd16;
			end
			3: begin
				src_word[4:0] = 5'd2;
				tgt_word[4:0] = 5'd2;
			end
			default: begin
				// mostly legal sizes, sometimes out of range to hit the clamp
				src_word[4:0] = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(2, 16))
					: 5'($urandom_range(0, 31));
				tgt_word[4:0] = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(2, 16))
					: 5'($urandom_range(0, 31));
			end
		endcase
		// distinct source symbols so numbers parse as intended
		foreach (taken[i])
			taken[i] = 1'b0;
		for (int k = 0; k < 16; k++) begin
			do
				b = 8'($urandom_range(0, 255));
			while (taken[b]);
			taken[b] = 1'b1;
			src_syms[k*8 +: 8] = b;
		end
		// sometimes repeat a symbol inside the base
		src_b = eff_base(src_word[4:0]);
		if ($urandom_range(0, 3) == 0) begin
			a_pos = $urandom_range(0, src_b - 2);
			b_pos = $urandom_range(a_pos + 1, src_b - 1);
			src_syms[b_pos*8 +: 8] = src_syms[a_pos*8 +: 8];
		end
		tgt_syms = {$urandom(), $urandom(), $urandom(), $urandom()};
		write_reg(REG_SRC_BASE, src_word);
		write_reg(REG_TGT_BASE, tgt_word);
		write_reg(REG_SRC_LO, src_syms[63:0]);
		write_reg(REG_SRC_HI, src_syms[127:64]);
		write_reg(REG_TGT_LO, tgt_syms[63:0]);
		write_reg(REG_TGT_HI, tgt_syms[127:64]);
		if (phase == 0) begin
			write_reg(REG_SPARE_A, {$urandom(), $urandom()});
			write_reg(REG_SPARE_B, {$urandom(), $urandom()});
		end
		cfg_valid <= 1'b0;
	endtask

	// one number: mostly well formed with random digits, some broken or noise
	task automatic send_number();
		in_word_t    w;
		logic [63:0] v;
		int          base_s;
		int          maxlen;
		int          len;
		int          shape;
		int          bad_pos;
		bit          neg;
		bit          burst;
		bit          zeros;
		base_s = eff_base(src_size_q);
		burst = ($urandom_range(0, 3) == 0);
		maxlen = 0;
		v = VALUE_CAP;
		while (v != 0) begin
			v = v / 64'(base_s);
			maxlen++;
		end
		if ($urandom_range(0, 99) < 12) begin
			// noise: arbitrary bytes, arbitrary end marks
			len = $urandom_range(1, 6);
			for (int k = 0; k < len; k++) begin
				w.in_char = ($urandom_range(0, 3) == 0) ? MINUS_CHAR
					: 8'($urandom_range(0, 255));
				w.in_last = 1'($urandom_range(0, 1));
				send_char(w, 1'b0, '0);
				sender_idle(burst);
			end
			return;
		end
		neg = ($urandom_range(0, 9) < 3);
		zeros = 1'b0;
		shape = $urandom_range(0, 19);
		if (shape < 9)
			len = $urandom_range(1, (maxlen < 4) ? maxlen : 4);
		else if (shape < 14)
			len = $urandom_range(1, maxlen);
		else if (shape < 16)
			len = maxlen;
		else if (shape < 18)
			len = maxlen + $urandom_range(1, 2);
		else if (shape == 18) begin
			// lone minus
			len = 0;
			neg = 1'b1;
		end else begin
			len = $urandom_range(1, 3);
			zeros = 1'b1;
		end
		bad_pos = (len > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
		if (neg) begin
			w.in_char = MINUS_CHAR;
			w.in_last = (len == 0);
			send_char(w, 1'b0, '0);
			sender_idle(burst);
		end
		for (int k = 0; k < len; k++) begin
			w.in_char = alpha_byte(src_lo_q, src_hi_q,
				zeros ? 0 : $urandom_range(0, base_s - 1));
			if (k == bad_pos)
				w.in_char = 8'($urandom_range(0, 255));
			w.in_last = (k == len - 1);
			send_char(w, 1'b0, '0);
			sender_idle(burst);
		end
	endtask

	// result side: check each popped word, then pick the next pop level
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (awaited_words.size() == 0) begin
				report_mismatch("unexpected word", out_word.out_char, 8'h00);
			end else begin
				out_word_t want;
				want = awaited_words.pop_front();
				if (out_word.out_char !== want.out_char)
					report_mismatch("out_char", out_word.out_char, want.out_char);
				if (out_word.out_last !== want.out_last)
					report_mismatch("out_last", 8'(out_word.out_last), 8'(want.out_last));
				if (out_word.status !== want.status)
					report_mismatch("status", 8'(out_word.status), 8'(want.status));
			end
			result_index++;
		end
		if (calm_left > 0) begin
			calm_left--;
			pop <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			pop_roll = $urandom_range(0, 99);
			if (pop_roll < 2)
				calm_left = $urandom_range(50, 200);
			else if (pop_roll < 6)
				stall_left = $urandom_range(10, 40);
			else if (pop_roll < 35)
				stall_left = $urandom_range(1, 3);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		bit        cfg_open;
		int        quota;
		in_word_t  w;
		cfg_open = 1'b0;

		// reset alphabets are all zero bytes, so only 0x00 is a digit
		row_typed(8'h00, 1'b1, result_word(ZERO_CHAR, 1'b1, ST_OK));
		row_char(MINUS_CHAR, 1'b0);
		row_typed(8'h00, 1'b1, result_word(ZERO_CHAR, 1'b1, ST_OK));
		row_typed(8'hFF, 1'b1, result_word(NULL_CHAR, 1'b1, ST_UNKNOWN));
		// lone minus gives a bare zero
		row_typed(MINUS_CHAR, 1'b1, result_word(ZERO_CHAR, 1'b1, ST_OK));
		// error keeps through the following digits
		row_char(8'h00, 1'b0);
		row_char("A", 1'b0);
		row_typed(8'h00, 1'b1, result_word(NULL_CHAR, 1'b1, ST_UNKNOWN));

		// decimal in, hex out
		row_cfg(REG_SRC_BASE, 64'd10);
		row_cfg(REG_TGT_BASE, 64'd16);
		row_cfg(REG_SRC_LO, HEX_SYMS_LO);
		row_cfg(REG_SRC_HI, HEX_SYMS_HI);
		row_cfg(REG_TGT_LO, HEX_SYMS_LO);
		row_cfg(REG_TGT_HI, HEX_SYMS_HI);
		row_typed("7", 1'b1, result_word("7", 1'b1, ST_OK));
		row_char(MINUS_CHAR, 1'b0);
		row_char("9", 1'b1);
		// minus after a digit is just an unknown symbol
		row_char("1", 1'b0);
		row_typed(MINUS_CHAR, 1'b1, result_word(NULL_CHAR, 1'b1, ST_UNKNOWN));
		row_char("2", 1'b0);
		row_char("5", 1'b0);
		row_char("5", 1'b1);
		// negative zero loses its sign
		row_char(MINUS_CHAR, 1'b0);
		row_char("0", 1'b0);
		row_typed("0", 1'b1, result_word(ZERO_CHAR, 1'b1, ST_OK));

		// sizes out of range: source acts as base 2, target as base 16
		row_cfg(REG_SRC_BASE, 64'hFFFF_FFFF_FFFF_FFE0);
		row_cfg(REG_TGT_BASE, 64'h1F);
		// symbol past the base is not a digit
		row_char("1", 1'b0);
		row_typed("2", 1'b1, result_word(NULL_CHAR, 1'b1, ST_UNKNOWN));
		row_char("1", 1'b0);
		row_typed("1", 1'b1, result_word("3", 1'b1, ST_OK));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < stim_table.size(); i++) begin
			row = stim_table[i];
			if (row.kind == ROW_CFG) begin
				if (!cfg_open)
					drain_results();
				write_reg(row.reg_index, row.reg_data);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) begin
					cfg_valid <= 1'b0;
					cfg_open = 1'b0;
				end
				send_char(row.word, row.typed, row.want);
				sender_idle(1'b0);
			end
		end

		// random phases, each under its own register setting
		for (int phase = 0; phase < 8; phase++) begin
			configure(phase);
			quota = items_sent + PHASE_ITEMS;
			while (items_sent < quota) begin
				send_number();
				// occasional full pause with results still draining
				if ($urandom_range(0, 19) == 0)
					drain_results();
			end
			// close a number left open by noise
			if (number_open) begin
				w.in_char = 8'($urandom_range(0, 255));
				w.in_last = 1'b1;
				send_char(w, 1'b0, '0);
			end
		end

		push <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/rsc_pkg.sv
sv/rsc_ram.sv
sv/rsc_front.sv
sv/rsc_job_fifo.sv
sv/rsc_back.sv
sv/radix_string_converter_unit.sv
verif/testbench.sv
